FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of the interval timer.
// No dependencies; include this file by its bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent in one cycle implies consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Antecedent in one cycle implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/swit_pkg.sv
// Shared types, codes and defaults for the square-wave interval timer.
// Used by every module of the block; depends on nothing.
package swit_pkg;

  localparam int MAX_CHANNELS         = 3;
  localparam int NUM_CHANNELS_DEFAULT = 3;
  localparam int COUNT_WIDTH_DEFAULT  = 16;
  localparam int SPK_CHANNEL          = 2;
  localparam int QUEUE_DEPTH          = 2;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [2:0] PORT_CMD = 3'd3;
  localparam logic [2:0] PORT_SPK = 3'd4;

  localparam logic [1:0] SEL_READBACK = 2'd3;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_TICK,
    OP_LOAD,
    OP_STOP,
    OP_SPK_WRITE,
    OP_SPK_READ
  } op_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [2:0] port_sel;
    logic [7:0] wdata;
  } in_item_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       timer_out;
    logic       refresh_out;
    logic       speaker_out;
  } out_item_t;

  typedef struct packed {
    op_e        kind;
    logic [1:0] chan;
    logic [7:0] data;
  } op_t;

endpackage

FILE: rtl/swit_front.sv
// Front end of the interval timer: accepts items and classifies them into operations.
// Depends on swit_pkg; feeds swit_queue.
module swit_front #(
  parameter int NUM_CHANNELS = swit_pkg::NUM_CHANNELS_DEFAULT
) (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  swit_pkg::in_item_t in_item_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output swit_pkg::op_t     q_op_o
);

  swit_pkg::op_t op;

  always_comb begin
    op.kind = swit_pkg::OP_NOP;
    op.chan = in_item_i.port_sel[1:0];
    op.data = in_item_i.wdata;
    case (in_item_i.cmd)
      swit_pkg::CMD_WRITE: begin
        if (in_item_i.port_sel < swit_pkg::PORT_CMD) begin
          if (int'(in_item_i.port_sel) < NUM_CHANNELS) begin
            op.kind = swit_pkg::OP_LOAD;
          end
        end else if (in_item_i.port_sel == swit_pkg::PORT_CMD) begin
          op.chan = in_item_i.wdata[7:6];
          if ((in_item_i.wdata[7:6] != swit_pkg::SEL_READBACK) &&
              (int'(in_item_i.wdata[7:6]) < NUM_CHANNELS)) begin
            op.kind = swit_pkg::OP_STOP;
          end
        end else if (in_item_i.port_sel == swit_pkg::PORT_SPK) begin
          op.kind = swit_pkg::OP_SPK_WRITE;
        end
      end
      swit_pkg::CMD_READ: begin
        if (in_item_i.port_sel == swit_pkg::PORT_SPK) begin
          op.kind = swit_pkg::OP_SPK_READ;
        end
      end
      swit_pkg::CMD_TICK: begin
        op.kind = swit_pkg::OP_TICK;
      end
      default: begin
        op.kind = swit_pkg::OP_NOP;
      end
    endcase
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;
  assign q_op_o     = op;

endmodule

FILE: rtl/swit_queue.sv
// Short operation queue between the front and back ends of the interval timer.
// Depends on swit_pkg for the operation type and depth.
module swit_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  swit_pkg::op_t op_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output swit_pkg::op_t op_o
);

  localparam int PtrW = (swit_pkg::QUEUE_DEPTH > 1) ? $clog2(swit_pkg::QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(swit_pkg::QUEUE_DEPTH + 1);

  swit_pkg::op_t entry_q [swit_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic do_pop;

  assign full_o  = (count_q == CntW'(swit_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign op_o    = entry_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (int'(wr_ptr_q) == swit_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (int'(rd_ptr_q) == swit_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

FILE: rtl/swit_back.sv
// Back end of the interval timer: channel counters, speaker control and result register.
// Depends on swit_pkg; consumes operations from swit_queue.
module swit_back #(
  parameter int NUM_CHANNELS = swit_pkg::NUM_CHANNELS_DEFAULT,
  parameter int COUNT_WIDTH  = swit_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  swit_pkg::op_t       q_op_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output swit_pkg::out_item_t out_item_o
);

  logic advance;
  logic out_valid_q, out_valid_d;
  swit_pkg::out_item_t out_item_q, out_item_d;
  logic [7:0] spk_q, spk_d;
  logic [swit_pkg::MAX_CHANNELS-1:0] lvl_nxt;

  assign advance = q_valid_i && (!out_valid_q || !out_stall_i);
  assign q_pop_o = advance;

  for (genvar c = 0; c < swit_pkg::MAX_CHANNELS; c++) begin : g_chan
    if (c < NUM_CHANNELS) begin : g_live
      localparam bit IsSpk = (c == swit_pkg::SPK_CHANNEL);

      logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
      logic [COUNT_WIDTH-1:0] rld_q, rld_d;
      logic [7:0]             hold_q, hold_d;
      logic                   exp_q, exp_d;
      logic                   run_q, run_d;
      logic                   lvl_q, lvl_d;
      logic [COUNT_WIDTH:0]   div, div_inc, new_div, new_inc;
      logic [15:0]            wr_word;
      logic [COUNT_WIDTH-1:0] new_rld, hi, lo, new_hi;
      logic                   gate, hit;

      assign div     = {rld_q == '0, rld_q};
      assign div_inc = div + 1'b1;
      assign hi      = div_inc[COUNT_WIDTH:1];
      assign lo      = div[COUNT_WIDTH:1];
      assign wr_word = {q_op_i.data, hold_q};
      assign new_rld = wr_word[COUNT_WIDTH-1:0];
      assign new_div = {new_rld == '0, new_rld};
      assign new_inc = new_div + 1'b1;
      assign new_hi  = new_inc[COUNT_WIDTH:1];
      assign gate    = !IsSpk || spk_q[0];
      assign hit     = (q_op_i.chan == 2'(c));

      always_comb begin
        cnt_d  = cnt_q;
        rld_d  = rld_q;
        hold_d = hold_q;
        exp_d  = exp_q;
        run_d  = run_q;
        lvl_d  = lvl_q;
        if (advance) begin
          case (q_op_i.kind)
            swit_pkg::OP_TICK: begin
              if (run_q && gate) begin
                if (cnt_q > COUNT_WIDTH'(1)) begin
                  cnt_d = cnt_q - 1'b1;
                end else if (lvl_q) begin
                  if (lo == '0) begin
                    cnt_d = hi;
                  end else begin
                    lvl_d = 1'b0;
                    cnt_d = lo;
                  end
                end else begin
                  lvl_d = 1'b1;
                  cnt_d = hi;
                end
              end
            end
            swit_pkg::OP_LOAD: begin
              if (hit) begin
                if (!exp_q) begin
                  hold_d = q_op_i.data;
                  exp_d  = 1'b1;
                end else begin
                  rld_d = new_rld;
                  exp_d = 1'b0;
                  run_d = 1'b1;
                  lvl_d = 1'b1;
                  cnt_d = new_hi;
                end
              end
            end
            swit_pkg::OP_STOP: begin
              if (hit) begin
                run_d = 1'b0;
                lvl_d = 1'b1;
                exp_d = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          cnt_q  <= '0;
          rld_q  <= '0;
          hold_q <= '0;
          exp_q  <= 1'b0;
          run_q  <= 1'b0;
          lvl_q  <= 1'b1;
        end else begin
          cnt_q  <= cnt_d;
          rld_q  <= rld_d;
          hold_q <= hold_d;
          exp_q  <= exp_d;
          run_q  <= run_d;
          lvl_q  <= lvl_d;
        end
      end

      assign lvl_nxt[c] = lvl_d;
    end else begin : g_absent
      assign lvl_nxt[c] = 1'b1;
    end
  end

  always_comb begin
    spk_d = spk_q;
    if (advance && (q_op_i.kind == swit_pkg::OP_SPK_WRITE)) begin
      spk_d = q_op_i.data;
    end
  end

  always_comb begin
    out_item_d.rdata       = (q_op_i.kind == swit_pkg::OP_SPK_READ) ? spk_q : 8'd0;
    out_item_d.timer_out   = lvl_nxt[0];
    out_item_d.refresh_out = lvl_nxt[1];
    out_item_d.speaker_out = lvl_nxt[swit_pkg::SPK_CHANNEL] & spk_d[1];
  end

  always_comb begin
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      spk_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      spk_q       <= spk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

FILE: rtl/square_wave_interval_timer.sv
// Top level of the three-channel square-wave interval timer with speaker gate.
// Depends on swit_pkg, swit_front, swit_queue and swit_back.
//
// Each item is a port write, a port read or one tick of the input clock, and each
// yields one result with the read byte and the three output levels after the item.
// The block takes one item per clock cycle unless the result is stalled. Each accepted
// item is written into a queue entry and then into the result register; the front
// decodes into a two-entry queue, and the back end updates every channel counter at
// once, so the per-channel count, compare and reload set the cycle time. While the
// result is stalled, up to two further items are taken before the input stalls.
module square_wave_interval_timer #(
  parameter int NUM_CHANNELS = swit_pkg::NUM_CHANNELS_DEFAULT,
  parameter int COUNT_WIDTH  = swit_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  swit_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output swit_pkg::out_item_t out_item_o
);

  logic          q_full;
  logic          q_push;
  logic          q_pop;
  logic          q_valid;
  swit_pkg::op_t push_op;
  swit_pkg::op_t head_op;

  swit_front #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_front (
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_item_i (in_item_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_op_o    (push_op)
  );

  swit_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .op_i   (push_op),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .op_o   (head_op)
  );

  swit_back #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_op_i     (head_op),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule

FILE: rtl/swit_checker.sv
// Port-level assertions for the interval timer, bound to the top level.
// Depends on swit_pkg and assert_macros.svh.
`include "assert_macros.svh"

module swit_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input swit_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input swit_pkg::out_item_t out_item_o
);

  `ASSERT_NEXT(a_out_held, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_item_o))
  `ASSERT_NEXT(a_in_stable, clk_i, rst_ni, in_valid_i && in_stall_o, $stable(in_item_i))
  `ASSERT_SAME(a_no_stall_when_empty, clk_i, rst_ni, !out_valid_o, !in_stall_o)
  `ASSERT_SAME(a_stall_cause, clk_i, rst_ni, $rose(in_stall_o),
    $past(in_valid_i && out_valid_o && out_stall_i))

endmodule

bind square_wave_interval_timer swit_checker u_swit_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_item_i  (in_item_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_item_o (out_item_o)
);
